### rtl/core/ste_pkg.sv
// shared types and constants for the sprite tile expander
package ste_pkg;

	localparam int TILE_W = 15;
	localparam int POS_W  = 10;
	localparam int IDX_W  = 6;
	localparam int PEN_W  = 16;
	localparam int PAL_W  = 4;

	localparam logic signed [POS_W-1:0] POS_LOW = -10'sd64;

	localparam int ATTR_FLIP_X = 0;
	localparam int ATTR_FLIP_Y = 1;
	localparam int ATTR_ENABLE = 2;
	localparam int ATTR_FLASH  = 5;

	localparam logic [1:0] PRIO_THROUGH = 2'd3;

	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_32 = 2'd2;
	localparam logic [1:0] SIZE_64 = 2'd3;

	typedef struct packed {
		logic             load;
		logic             emit;
		logic [IDX_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic keep;
		logic last;
	} dp_stat_t;

endpackage

### rtl/core/sprite_tile_expander_top.sv
// top level of the sprite tile expander: controller, datapath and checks
//
// channel   handshake                 payload
// sprite    start / busy              attr_word tile_base color_size_word ypos_word
//                                     xpos_word draw_priority frame_odd
// tile      tile_valid strobe         tile_code palette pos_x pos_y mirror_x mirror_y
//                                     through_mode key_pen last
// config    cfg_valid / cfg_ready     cfg_data (through pen)
//
// a kept sprite of size code s yields 4^s tile beats (1, 4, 16 or 64), one tile
// beat a cycle from the tile index counter, with busy held meanwhile; a rejected sprite leaves busy low
// tile beats appear in the cycle after the counter, through the output register
// reset is asynchronous, active low, and needs no clearing pass
// the tile receiver cannot stall: each beat is on the ports for one cycle
module sprite_tile_expander_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [15:0]                       attr_word,
	input  logic [15:0]                       tile_base,
	input  logic [15:0]                       color_size_word,
	input  logic [15:0]                       ypos_word,
	input  logic [15:0]                       xpos_word,
	input  logic [1:0]                        draw_priority,
	input  logic                              frame_odd,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [15:0]                       cfg_data,
	output logic                              tile_valid,
	output logic [ste_pkg::TILE_W-1:0]        tile_code,
	output logic [ste_pkg::PAL_W-1:0]         palette,
	output logic signed [ste_pkg::POS_W-1:0]  pos_x,
	output logic signed [ste_pkg::POS_W-1:0]  pos_y,
	output logic                              mirror_x,
	output logic                              mirror_y,
	output logic                              through_mode,
	output logic [ste_pkg::PEN_W-1:0]         key_pen,
	output logic                              last
);

	ste_pkg::dp_cmd_t  cmd;
	ste_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ste_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	ste_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.attr_word       (attr_word),
		.tile_base       (tile_base),
		.color_size_word (color_size_word),
		.ypos_word       (ypos_word),
		.xpos_word       (xpos_word),
		.draw_priority   (draw_priority),
		.frame_odd       (frame_odd),
		.tile_valid      (tile_valid),
		.tile_code       (tile_code),
		.palette         (palette),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.mirror_x        (mirror_x),
		.mirror_y        (mirror_y),
		.through_mode    (through_mode),
		.key_pen         (key_pen),
		.last            (last)
	);

	a_beat_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid |-> $past(busy))
		else $error("tile beat without a sprite in progress");

	a_burst_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !last |=> tile_valid)
		else $error("tile burst broken before last beat");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && last |=> !tile_valid)
		else $error("tile beat straight after last beat");

	a_busy_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		tile_valid && !last |-> busy)
		else $error("controller idle in the middle of a burst");

endmodule

### rtl/core/ste_ctrl.sv
// controller state machine stepping the tile index of a kept sprite
module ste_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ste_pkg::dp_stat_t stat,
	output ste_pkg::dp_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [ste_pkg::IDX_W-1:0]    idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start && stat.keep) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (stat.last) begin
						state_q <= ST_IDLE;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					idx_q   <= '0;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.emit = (state_q == ST_EMIT);
	assign cmd.idx  = idx_q;

endmodule

### rtl/core/ste_dp.sv
// datapath: sprite culling, tile offset mirroring and result register
module ste_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ste_pkg::dp_cmd_t                    cmd,
	output ste_pkg::dp_stat_t                   stat,
	input  logic                                cfg_valid,
	input  logic [15:0]                         cfg_data,
	input  logic [15:0]                         attr_word,
	input  logic [15:0]                         tile_base,
	input  logic [15:0]                         color_size_word,
	input  logic [15:0]                         ypos_word,
	input  logic [15:0]                         xpos_word,
	input  logic [1:0]                          draw_priority,
	input  logic                                frame_odd,
	output logic                                tile_valid,
	output logic [ste_pkg::TILE_W-1:0]          tile_code,
	output logic [ste_pkg::PAL_W-1:0]           palette,
	output logic signed [ste_pkg::POS_W-1:0]    pos_x,
	output logic signed [ste_pkg::POS_W-1:0]    pos_y,
	output logic                                mirror_x,
	output logic                                mirror_y,
	output logic                                through_mode,
	output logic [ste_pkg::PEN_W-1:0]           key_pen,
	output logic                                last
);

	logic [ste_pkg::PEN_W-1:0]          through_pen_q;
	logic                               flip_x_q;
	logic                               flip_y_q;
	logic [ste_pkg::TILE_W-1:0]         base_q;
	logic [ste_pkg::PAL_W-1:0]          pal_q;
	logic signed [ste_pkg::POS_W-1:0]   sx_q;
	logic signed [ste_pkg::POS_W-1:0]   sy_q;
	logic [1:0]                         size_q;
	logic                               thru_q;

	logic signed [ste_pkg::POS_W-1:0]   sx_w;
	logic signed [ste_pkg::POS_W-1:0]   sy_w;
	logic                               flash_ok;
	logic [2:0]                         span;
	logic [ste_pkg::IDX_W-1:0]          last_idx;
	logic [2:0]                         dx;
	logic [2:0]                         dy;
	logic [2:0]                         dx_m;
	logic [2:0]                         dy_m;
	logic                               is_last;

	logic                               tile_valid_q;
	logic [ste_pkg::TILE_W-1:0]         tile_code_q;
	logic [ste_pkg::PAL_W-1:0]          palette_q;
	logic signed [ste_pkg::POS_W-1:0]   pos_x_q;
	logic signed [ste_pkg::POS_W-1:0]   pos_y_q;
	logic                               mirror_x_q;
	logic                               mirror_y_q;
	logic                               through_mode_q;
	logic [ste_pkg::PEN_W-1:0]          key_pen_q;
	logic                               last_q;

	// nine bit positions wrap to -256..255
	assign sx_w     = {xpos_word[8], xpos_word[8:0]};
	assign sy_w     = {ypos_word[8], ypos_word[8:0]};
	assign flash_ok = !attr_word[ste_pkg::ATTR_FLASH] || frame_odd;

	assign stat.keep = attr_word[ste_pkg::ATTR_ENABLE]
		&& (attr_word[7:6] == draw_priority)
		&& flash_ok
		&& (sx_w > ste_pkg::POS_LOW)
		&& (sy_w > ste_pkg::POS_LOW);

	always_comb begin
		case (size_q)
			ste_pkg::SIZE_8: begin
				span     = 3'd0;
				last_idx = 6'd0;
			end
			ste_pkg::SIZE_16: begin
				span     = 3'd1;
				last_idx = 6'd3;
			end
			ste_pkg::SIZE_32: begin
				span     = 3'd3;
				last_idx = 6'd15;
			end
			default: begin
				span     = 3'd7;
				last_idx = 6'd63;
			end
		endcase
	end

	// morton order: even index bits give the column, odd bits the row
	assign dx      = {cmd.idx[4], cmd.idx[2], cmd.idx[0]};
	assign dy      = {cmd.idx[5], cmd.idx[3], cmd.idx[1]};
	assign dx_m    = flip_x_q ? (span - dx) : dx;
	assign dy_m    = flip_y_q ? (span - dy) : dy;
	assign is_last = (cmd.idx == last_idx);

	assign stat.last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			through_pen_q <= '0;
			tile_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				through_pen_q <= cfg_data;
			end
			tile_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flip_x_q <= attr_word[ste_pkg::ATTR_FLIP_X];
			flip_y_q <= attr_word[ste_pkg::ATTR_FLIP_Y];
			base_q   <= tile_base[ste_pkg::TILE_W-1:0];
			pal_q    <= color_size_word[7:4];
			sx_q     <= sx_w;
			sy_q     <= sy_w;
			size_q   <= color_size_word[1:0];
			thru_q   <= (draw_priority == ste_pkg::PRIO_THROUGH);
		end
		if (cmd.emit) begin
			tile_code_q    <= base_q + {{(ste_pkg::TILE_W-ste_pkg::IDX_W){1'b0}}, cmd.idx};
			palette_q      <= pal_q;
			pos_x_q        <= sx_q + $signed({4'b0000, dx_m, 3'b000});
			pos_y_q        <= sy_q + $signed({4'b0000, dy_m, 3'b000});
			mirror_x_q     <= flip_x_q;
			mirror_y_q     <= flip_y_q;
			through_mode_q <= thru_q;
			key_pen_q      <= thru_q ? through_pen_q : '0;
			last_q         <= is_last;
		end
	end

	assign tile_valid   = tile_valid_q;
	assign tile_code    = tile_code_q;
	assign palette      = palette_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign mirror_x     = mirror_x_q;
	assign mirror_y     = mirror_y_q;
	assign through_mode = through_mode_q;
	assign key_pen      = key_pen_q;
	assign last         = last_q;

endmodule

### tb/tb_sprite_tile_expander_top.sv
`timescale 1ns / 1ps
// testbench for the sprite tile expander: directed and random sprites checked by a scoreboard
module tb_sprite_tile_expander_top;
	import ste_pkg::*;

	localparam int WINDOW_END    = 256;
	localparam int ATTR_PRIO_LSB = 6;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_SPRITES = 75;

	localparam logic [15:0] A_FLIP_X = 16'(1) << ATTR_FLIP_X;
	localparam logic [15:0] A_FLIP_Y = 16'(1) << ATTR_FLIP_Y;
	localparam logic [15:0] A_ENABLE = 16'(1) << ATTR_ENABLE;
	localparam logic [15:0] A_FLASH  = 16'(1) << ATTR_FLASH;

	typedef struct packed {
		logic [15:0] attr_word;
		logic [15:0] tile_base;
		logic [15:0] color_size_word;
		logic [15:0] ypos_word;
		logic [15:0] xpos_word;
		logic [1:0]  draw_priority;
		logic        frame_odd;
	} sprite_t;

	typedef struct packed {
		logic [TILE_W-1:0]        tile_code;
		logic [PAL_W-1:0]         palette;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic                     mirror_x;
		logic                     mirror_y;
		logic                     through_mode;
		logic [PEN_W-1:0]         key_pen;
		logic                     last;
	} tile_beat_t;

	class tile_scoreboard;
		tile_beat_t  pending_tiles[$];
		logic [15:0] through_pen;
		int          sprites_noted;
		int          sprites_kept;
		int          tiles_checked;
		int          mismatches;

		function new();
			through_pen   = '0;
			sprites_noted = 0;
			sprites_kept  = 0;
			tiles_checked = 0;
			mismatches    = 0;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch: %s", what);
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want) begin
				report_mismatch($sformatf("%s is %0h, expected %0h at tile beat %0d",
					name, got, want, tiles_checked));
			end
		endtask

		// expands one accepted sprite into the tile beats it should produce
		function void note_sprite(sprite_t s);
			int          sx;
			int          sy;
			int          count;
			int          px;
			int          py;
			logic [1:0]  size;
			logic [2:0]  span;
			logic [2:0]  dx;
			logic [2:0]  dy;
			logic [5:0]  idx;
			logic [15:0] code;
			tile_beat_t  beat;
			sprites_noted++;
			sx = $signed(s.xpos_word[8:0]);
			sy = $signed(s.ypos_word[8:0]);
			if (!s.attr_word[ATTR_ENABLE] ||
			    s.attr_word[ATTR_PRIO_LSB +: 2] != s.draw_priority ||
			    (s.attr_word[ATTR_FLASH] && !s.frame_odd) ||
			    sx <= POS_LOW || sx >= WINDOW_END || sy <= POS_LOW || sy >= WINDOW_END)
				return;
			sprites_kept++;
			size  = s.color_size_word[1:0];
			count = 1 << (2 * size);
			span  = 3'((1 << size) - 1);
			for (int i = 0; i < count; i++) begin
				// morton order: even index bits give the column, odd bits the row
				idx = 6'(i);
				dx  = {idx[4], idx[2], idx[0]};
				dy  = {idx[5], idx[3], idx[1]};
				if (s.attr_word[ATTR_FLIP_X])
					dx = span - dx;
				if (s.attr_word[ATTR_FLIP_Y])
					dy = span - dy;
				px   = sx + 8 * int'(dx);
				py   = sy + 8 * int'(dy);
				code = s.tile_base + 16'(i);
				beat.tile_code    = code[TILE_W-1:0];
				beat.palette      = s.color_size_word[7:4];
				beat.pos_x        = px[POS_W-1:0];
				beat.pos_y        = py[POS_W-1:0];
				beat.mirror_x     = s.attr_word[ATTR_FLIP_X];
				beat.mirror_y     = s.attr_word[ATTR_FLIP_Y];
				beat.through_mode = (s.draw_priority == PRIO_THROUGH);
				beat.key_pen      = beat.through_mode ? through_pen : '0;
				beat.last         = (i == count - 1);
				pending_tiles.push_back(beat);
			end
		endfunction

		task check_tile(tile_beat_t got);
			tile_beat_t want;
			tiles_checked++;
			if (pending_tiles.size() == 0) begin
				report_mismatch($sformatf("tile beat %0d with no tile expected", tiles_checked));
				return;
			end
			want = pending_tiles.pop_front();
			compare_field("tile_code", 16'(got.tile_code), 16'(want.tile_code));
			compare_field("palette", 16'(got.palette), 16'(want.palette));
			compare_field("pos_x", 16'(got.pos_x), 16'(want.pos_x));
			compare_field("pos_y", 16'(got.pos_y), 16'(want.pos_y));
			compare_field("mirror_x", 16'(got.mirror_x), 16'(want.mirror_x));
			compare_field("mirror_y", 16'(got.mirror_y), 16'(want.mirror_y));
			compare_field("through_mode", 16'(got.through_mode), 16'(want.through_mode));
			compare_field("key_pen", got.key_pen, want.key_pen);
			compare_field("last", 16'(got.last), 16'(want.last));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [15:0]              attr_word;
	logic [15:0]              tile_base;
	logic [15:0]              color_size_word;
	logic [15:0]              ypos_word;
	logic [15:0]              xpos_word;
	logic [1:0]               draw_priority;
	logic                     frame_odd;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [15:0]              cfg_data;
	logic                     tile_valid;
	logic [TILE_W-1:0]        tile_code;
	logic [PAL_W-1:0]         palette;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic                     mirror_x;
	logic                     mirror_y;
	logic                     through_mode;
	logic [PEN_W-1:0]         key_pen;
	logic                     last;

	tile_scoreboard sb;
	int             quiet_cycles = 0;
	int             pen_writes = 0;

	sprite_tile_expander_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.attr_word       (attr_word),
		.tile_base       (tile_base),
		.color_size_word (color_size_word),
		.ypos_word       (ypos_word),
		.xpos_word       (xpos_word),
		.draw_priority   (draw_priority),
		.frame_odd       (frame_odd),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.tile_valid      (tile_valid),
		.tile_code       (tile_code),
		.palette         (palette),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.mirror_x        (mirror_x),
		.mirror_y        (mirror_y),
		.through_mode    (through_mode),
		.key_pen         (key_pen),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_sprite(sprite_t'{attr_word, tile_base, color_size_word, ypos_word,
				xpos_word, draw_priority, frame_odd});
		end
		if (arst_n && tile_valid) begin
			sb.check_tile(tile_beat_t'{tile_code, palette, pos_x, pos_y, mirror_x, mirror_y,
				through_mode, key_pen, last});
		end
		if (arst_n && ((start && !busy) || tile_valid || (cfg_valid && cfg_ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic logic [15:0] prio_bits(logic [1:0] prio);
		return {8'h00, prio, 6'h00};
	endfunction

	function automatic logic [15:0] csw_of(logic [3:0] pal, logic [1:0] size);
		return {8'h00, pal, 2'b00, size};
	endfunction

	function automatic sprite_t mk_sprite(logic [15:0] attr, logic [15:0] base,
			logic [15:0] csw, logic [15:0] y, logic [15:0] x, logic [1:0] prio, logic odd);
		return sprite_t'{attr, base, csw, y, x, prio, odd};
	endfunction

	// mostly inside the window, now and then right on its borders
	function automatic logic [8:0] pick_pos();
		int v;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: v = -64;
				1: v = -63;
				2: v = 255;
				default: v = 256;
			endcase
		end else begin
			v = int'($urandom_range(0, 318)) - 63;
		end
		return 9'(v);
	endfunction

	// mostly sprites that pass the filters, the rest plain noise
	function automatic sprite_t rand_sprite();
		sprite_t s;
		int      roll;
		s.attr_word       = 16'($urandom);
		s.tile_base       = 16'($urandom);
		s.color_size_word = 16'($urandom);
		s.ypos_word       = 16'($urandom);
		s.xpos_word       = 16'($urandom);
		s.draw_priority   = 2'($urandom_range(0, 3));
		s.frame_odd       = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 20)
			return s;
		s.attr_word[ATTR_ENABLE] = 1'b1;
		s.attr_word[ATTR_PRIO_LSB +: 2] = s.draw_priority;
		if (s.attr_word[ATTR_FLASH] && $urandom_range(0, 9) != 0)
			s.frame_odd = 1'b1;
		roll = $urandom_range(0, 99);
		s.color_size_word[1:0] = roll < 50 ? SIZE_8 : roll < 80 ? SIZE_16 :
			roll < 95 ? SIZE_32 : SIZE_64;
		s.xpos_word[8:0] = pick_pos();
		s.ypos_word[8:0] = pick_pos();
		return s;
	endfunction

	task automatic send_sprite(sprite_t s);
		attr_word       = s.attr_word;
		tile_base       = s.tile_base;
		color_size_word = s.color_size_word;
		ypos_word       = s.ypos_word;
		xpos_word       = s.xpos_word;
		draw_priority   = s.draw_priority;
		frame_odd       = s.frame_odd;
		start           = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			start = 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (sb.pending_tiles.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_through_pen(logic [15:0] pen);
		wait_idle();
		cfg_data  = pen;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.through_pen = pen;
		pen_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(int sprites);
		int goal;
		int burst;
		bit drained;
		goal    = sb.sprites_noted + sprites;
		drained = 1'b0;
		while (sb.sprites_noted < goal) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
			repeat (burst) send_sprite(rand_sprite());
			pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
			if (!drained && sb.sprites_noted >= goal - sprites / 2) begin
				wait_idle();
				drained = 1'b1;
			end
		end
	endtask

	initial begin
		logic [15:0] pen_plan [4];
		sb              = new();
		arst_n          = 1'b0;
		start           = 1'b0;
		attr_word       = '0;
		tile_base       = '0;
		color_size_word = '0;
		ypos_word       = '0;
		xpos_word       = '0;
		draw_priority   = '0;
		frame_odd       = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		pen_plan[0]     = 16'hffff;
		pen_plan[1]     = 16'($urandom);
		pen_plan[2]     = 16'h0000;
		pen_plan[3]     = 16'($urandom);
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// filters: disabled, wrong priority, flashing on even and odd frames
		send_sprite(mk_sprite(16'h0000, 16'h0100, csw_of(4'h1, SIZE_16), 16'd10, 16'd10, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE | prio_bits(2'd1), 16'h0200, csw_of(4'h2, SIZE_8),
			16'd20, 16'd20, 2'd0, 1'b1));
		send_sprite(mk_sprite(A_ENABLE | A_FLASH, 16'h0300, csw_of(4'h3, SIZE_8),
			16'd30, 16'd30, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE | A_FLASH, 16'h0301, csw_of(4'h3, SIZE_8),
			16'd30, 16'd30, 2'd0, 1'b1));
		// window borders in x, then in y
		send_sprite(mk_sprite(A_ENABLE, 16'h0400, csw_of(4'h4, SIZE_8), 16'd5, 16'h01c0, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0401, csw_of(4'h4, SIZE_8), 16'd5, 16'h01c1, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0402, csw_of(4'h4, SIZE_8), 16'd5, 16'h00ff, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0403, csw_of(4'h4, SIZE_8), 16'd5, 16'h0100, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0500, csw_of(4'h5, SIZE_8), 16'h01c0, 16'd5, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0501, csw_of(4'h5, SIZE_8), 16'h01c1, 16'd5, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0502, csw_of(4'h5, SIZE_8), 16'h00ff, 16'd5, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0503, csw_of(4'h5, SIZE_8), 16'h0100, 16'd5, 2'd0, 1'b0));
		// sizes 16, 32 and 64, and every flip
		send_sprite(mk_sprite(A_ENABLE | prio_bits(2'd1), 16'h0600, csw_of(4'h6, SIZE_16),
			16'd40, 16'd40, 2'd1, 1'b0));
		send_sprite(mk_sprite(A_ENABLE | A_FLIP_X | prio_bits(2'd1), 16'h0610,
			csw_of(4'h7, SIZE_16), 16'd40, 16'd40, 2'd1, 1'b1));
		send_sprite(mk_sprite(A_ENABLE | A_FLIP_Y | prio_bits(2'd2), 16'h0620,
			csw_of(4'h8, SIZE_32), 16'd100, 16'd60, 2'd2, 1'b0));
		send_sprite(mk_sprite(A_ENABLE | A_FLIP_X | A_FLIP_Y | prio_bits(2'd2), 16'h0640,
			csw_of(4'h9, SIZE_64), 16'h1c1, 16'd200, 2'd2, 1'b0));
		// all ones, tile numbers wrapping, unused high bits set
		send_sprite(mk_sprite(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hfe00, 2'd3, 1'b1));
		send_sprite(mk_sprite(A_ENABLE | prio_bits(PRIO_THROUGH), 16'h7ffe,
			csw_of(4'hf, SIZE_16), 16'd0, 16'd248, 2'd3, 1'b0));
		send_sprite(mk_sprite(16'hff04, 16'h0700, 16'hff02, 16'hfe05, 16'hfe05, 2'd0, 1'b0));
		send_sprite(mk_sprite(A_ENABLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0, 1'b0));

		foreach (pen_plan[p]) begin
			write_through_pen(pen_plan[p]);
			run_phase(PHASE_SPRITES);
		end
		wait_idle();

		$display("summary: %0d sprites offered, %0d kept, %0d tile beats checked",
			sb.sprites_noted, sb.sprites_kept, sb.tiles_checked);
		$display("summary: %0d through pen settings over all sizes, flips, flashing and borders",
			pen_writes);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
